// ----- hw/rtl/bdq_pkg.sv -----
// shared types, codes and defaults for the bounded deque unit
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int OCC_W     = 7;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OCC_W-1:0]    occ_t;
  typedef logic [VAL_W-1:0]    val_t;

  // operation codes
  localparam func_t FN_PUSH_FRONT = 3'd0;
  localparam func_t FN_PUSH_BACK  = 3'd1;
  localparam func_t FN_POP_FRONT  = 3'd2;
  localparam func_t FN_POP_BACK   = 3'd3;
  localparam func_t FN_DUMP       = 3'd4;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic [STATUS_W-1:0]     status;
    logic                    last;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic exec;     // execute the transferred operation
    logic capture;  // load result register from read data
    logic step;     // advance dump cursor and read next entry
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic dump_last;
    logic op_dump;
  } sts_t;

endpackage

// ----- hw/rtl/bdq_ram.sv -----
// generic single write port ram with registered read
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bdq_ctrl.sv -----
// controller state machine for the bounded deque unit
module bdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  bdq_pkg::func_t func,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bdq_pkg::sts_t  sts,
  output bdq_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.exec    = 1'b0;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.exec = 1'b1;
          unique case (func) inside
            bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK: begin
              state_next = S_OUT;
            end
            bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK, bdq_pkg::FN_DUMP: begin
              state_next = sts.empty ? S_OUT : S_READ;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (sts.op_dump && !sts.dump_last && !sts.empty) begin
            cmd.step   = 1'b1;
            state_next = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/bdq_dp.sv -----
// datapath: ring pointers, entry ram, dump cursor and result register
module bdq_dp #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bdq_pkg::cmd_t       cmd,
  input  bdq_pkg::in_item_t   in_data,
  output bdq_pkg::sts_t       sts,
  output bdq_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  logic          op_dump;
  logic          op_dump_next;

  bdq_pkg::out_item_t out_q;
  bdq_pkg::out_item_t out_next;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  bdq_pkg::val_t       rdata;

  logic full;
  logic empty;
  logic dump_last;

  // (base + off) mod DEPTH with off below DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign dump_last = ((CW'(idx) + CW'(1)) == count);

  assign sts.empty     = empty;
  assign sts.dump_last = dump_last;
  assign sts.op_dump   = op_dump;

  assign out_data = out_q;

  always_comb begin
    front_next   = front;
    count_next   = count;
    idx_next     = idx;
    op_dump_next = op_dump;
    out_next     = out_q;
    we           = 1'b0;
    waddr        = front;
    raddr        = front;

    if (cmd.exec) begin
      op_dump_next = (in_data.func == bdq_pkg::FN_DUMP);
      case (in_data.func) inside
        bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK: begin
          if (full) begin
            out_next = '{out_value: '0, status: bdq_pkg::ST_FULL, last: 1'b1,
                         occupancy: bdq_pkg::occ_t'(count)};
          end else begin
            we = 1'b1;
            if (in_data.func == bdq_pkg::FN_PUSH_FRONT) begin
              front_next = ring_add(front, AW'(DEPTH - 1));
              waddr      = front_next;
            end else begin
              waddr = ring_add(front, count[AW-1:0]);
            end
            count_next = count + CW'(1);
            out_next   = '{out_value: '0, status: bdq_pkg::ST_OK, last: 1'b1,
                           occupancy: bdq_pkg::occ_t'(count_next)};
          end
        end
        bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK: begin
          if (empty) begin
            out_next = '{out_value: '0, status: bdq_pkg::ST_EMPTY, last: 1'b1,
                         occupancy: bdq_pkg::occ_t'(count)};
          end else begin
            count_next = count - CW'(1);
            if (in_data.func == bdq_pkg::FN_POP_FRONT) begin
              front_next = ring_add(front, AW'(1));
            end else begin
              raddr = ring_add(front, count_next[AW-1:0]);
            end
          end
        end
        bdq_pkg::FN_DUMP: begin
          idx_next = '0;
          if (empty) begin
            out_next = '{out_value: '0, status: bdq_pkg::ST_EMPTY, last: 1'b1,
                         occupancy: bdq_pkg::occ_t'(count)};
          end
        end
        default: begin
          op_dump_next = 1'b0;
        end
      endcase
    end

    if (cmd.step) begin
      idx_next = idx + AW'(1);
      raddr    = ring_add(front, idx_next);
    end

    if (cmd.capture) begin
      out_next = '{out_value: rdata, status: bdq_pkg::ST_OK,
                   last: op_dump ? dump_last : 1'b1,
                   occupancy: bdq_pkg::occ_t'(count)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= '0;
      count   <= '0;
      idx     <= '0;
      op_dump <= 1'b0;
    end else begin
      front   <= front_next;
      count   <= count_next;
      idx     <= idx_next;
      op_dump <= op_dump_next;
    end
  end

  always_ff @(posedge clk) begin
    out_q <= out_next;
  end

  bdq_ram #(
    .WIDTH(bdq_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_data.push_value),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

// ----- hw/rtl/bounded_deque_with_dump_unit.sv -----
// top level of the bounded double-ended queue with dump
// usage:
//   input channel (in_valid / in_stall / in_data) carries an operation and a
//   value: push front, push back, pop front, pop back or dump. a transfer
//   happens on a clock edge with in_valid high and in_stall low.
//   output channel (out_valid / out_stall / out_data) returns one result per
//   push or pop, one per stored entry on dump (last marks the final one),
//   and one flagged result for a full push or an empty pop or dump.
//   unknown operation codes are taken and dropped with no result.
// result sequencing:
//   push and every error result: result valid in the cycle after the transfer.
//   pop: the controller waits in S_READ for the ram read (it is registered), then presents the result in S_OUT.
//   dump of n entries: the first result and each later one, once the previous
//   result is taken, go through S_READ and then S_OUT, set by the single ram
//   read port and the registered read.
//   one item at a time: in_stall is high from the transfer until its final
//   result is taken, so no new operation is accepted until then.
// reset (rst, synchronous): queue empties, controller returns to idle.
//   ram contents are not cleared; only written entries are ever read.
// receiver stall: the result register holds its value while out_stall is
//   high, and the dump cursor does not move until the result is taken.
module bounded_deque_with_dump_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bdq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bdq_pkg::out_item_t out_data
);

  // command and status between controller and datapath
  bdq_pkg::cmd_t cmd;
  bdq_pkg::sts_t sts;

  // sequencing: accept, ram read wait, result hold
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (in_data.func),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring pointers, entry storage and result register
  bdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_data (in_data),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule
